/* design/vgib_pkg.sv */
// shared types, constants and helpers of the voxel grid index builder
// no dependencies; imported by the controller, the datapath and the top level
package vgib_pkg;

	localparam int MAX_RES    = 32;
	localparam int NSIDE      = MAX_RES + 1;
	localparam int BOX_DEPTH  = MAX_RES * MAX_RES * MAX_RES;
	localparam int NODE_DEPTH = NSIDE * NSIDE * NSIDE;
	localparam int BOX_AW     = $clog2(BOX_DEPTH);
	localparam int NODE_AW    = $clog2(NODE_DEPTH);
	localparam int BCW        = $clog2(MAX_RES);
	localparam int CW         = 6;
	localparam int TW         = CW + 1;
	localparam int VW         = 16;
	localparam int SW         = 4;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_QBOX  = 2'd2;
	localparam logic [1:0] CMD_QNODE = 2'd3;

	localparam logic [SW-1:0] SLOT_BOX_FINAL  = SW'(14);
	localparam logic [SW-1:0] SLOT_NODE_FINAL = SW'(6);
	localparam logic [SW-1:0] SLOT_CORNER_END = SW'(8);
	localparam logic [SW-1:0] SLOT_FACE_BASE  = SW'(9);

	typedef struct packed {
		logic [1:0]    cmd;
		logic [CW-1:0] coord_x;
		logic [CW-1:0] coord_y;
		logic [CW-1:0] coord_z;
		logic          occupied;
	} in_item_t;

	typedef struct packed {
		logic [SW-1:0] slot;
		logic [VW-1:0] index_value;
		logic          found;
		logic          last;
	} out_item_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_BOX_WALK,
		DP_NODE_WALK,
		DP_READ,
		DP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		SRC_MEM,
		SRC_BOX_CNT,
		SRC_NODE_CNT
	} emit_src_t;

	typedef struct packed {
		dp_op_t        op;
		logic          capture;
		logic          count_clr;
		logic          set_built;
		emit_src_t     src;
		logic [SW-1:0] slot;
		logic          last;
	} dp_cmd_t;

	typedef struct packed {
		logic       walk_done;
		logic       found;
		logic       out_free;
		logic [1:0] item_cmd;
	} dp_status_t;

	// flat lattice node address, z fastest
	function automatic logic [NODE_AW-1:0] node_addr(input logic [TW-1:0] x,
			input logic [TW-1:0] y, input logic [TW-1:0] z);
		int a;
		a = int'(x) * NSIDE * NSIDE + int'(y) * NSIDE + int'(z);
		return NODE_AW'(a);
	endfunction

	// box address from in-grid coordinates
	function automatic logic [BOX_AW-1:0] box_addr(input logic [TW-1:0] x,
			input logic [TW-1:0] y, input logic [TW-1:0] z);
		return {x[BCW-1:0], y[BCW-1:0], z[BCW-1:0]};
	endfunction

endpackage

/* design/vgib_datapath.sv */
// datapath of the voxel grid index builder: memories, walk counters, counts, result register
// depends on vgib_pkg
module vgib_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  vgib_pkg::dp_cmd_t   cmd,
	output vgib_pkg::dp_status_t status,
	input  vgib_pkg::in_item_t  in_item,
	input  logic                cfg_valid,
	input  logic [5:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output vgib_pkg::out_item_t out_item
);
	import vgib_pkg::*;

	// storage
	logic               occ_mem     [BOX_DEPTH];
	logic [BOX_AW-1:0]  box_idx_mem [BOX_DEPTH];
	logic               present_mem [NODE_DEPTH];
	logic [NODE_AW-1:0] node_idx_mem[NODE_DEPTH];

	logic               occ_rd_q, present_rd_q;
	logic [BOX_AW-1:0]  box_rd_q;
	logic [NODE_AW-1:0] node_rd_q;

	in_item_t       item_q;
	logic [CW-1:0]  grid_size_q;
	logic [CW-1:0]  n;
	logic           built_q;
	logic [VW-1:0]  box_cnt_q, node_cnt_q;
	logic [CW-1:0]  wx_q, wy_q, wz_q;
	logic [3:0]     wsub_q;
	logic           touch_q;
	logic           bw_v_s1, nw_v_s1, inr_s1, kind_box_s1;
	logic [BOX_AW-1:0] bw_addr_s1;
	out_item_t      out_q;
	logic           out_valid_q;

	// effective grid size
	always_comb begin
		if (grid_size_q == '0) n = CW'(1);
		else if (grid_size_q > CW'(MAX_RES)) n = CW'(MAX_RES);
		else n = grid_size_q;
	end

	// walk limits and end of walk
	logic [CW-1:0] lim;
	logic          walk_last, walk_adv, node_step_end;
	always_comb begin
		unique case (cmd.op)
			DP_CLEAR:     lim = CW'(MAX_RES - 1);
			DP_BOX_WALK:  lim = n - CW'(1);
			default:      lim = n;
		endcase
		walk_last     = (wx_q == lim) && (wy_q == lim) && (wz_q == lim);
		node_step_end = (cmd.op == DP_NODE_WALK) && (wsub_q == 4'd8);
		walk_adv      = (cmd.op == DP_CLEAR) || (cmd.op == DP_BOX_WALK) || node_step_end;
	end

	// corner box probed by the node walk
	logic [TW-1:0] nbx, nby, nbz;
	logic          nb_inr;
	always_comb begin
		nbx = TW'(wx_q) - TW'(1) + TW'(wsub_q[2]);
		nby = TW'(wy_q) - TW'(1) + TW'(wsub_q[1]);
		nbz = TW'(wz_q) - TW'(1) + TW'(wsub_q[0]);
		nb_inr = (nbx < TW'(n)) && (nby < TW'(n)) && (nbz < TW'(n));
	end

	// query target for the current slot
	logic          qbox, kind_box, t_inr;
	logic [2:0]    cidx, fidx;
	logic [TW-1:0] ox, oy, oz, tx, ty, tz, fstep;
	always_comb begin
		qbox = (item_q.cmd == CMD_QBOX);
		ox = '0; oy = '0; oz = '0;
		cidx = 3'(cmd.slot - SW'(1));
		fidx = qbox ? 3'(cmd.slot - SLOT_FACE_BASE) : 3'(cmd.slot - SW'(1));
		fstep = (fidx < 3'd3) ? '1 : TW'(1);
		kind_box = qbox;
		if (cmd.slot == '0) begin
			kind_box = qbox;
		end else if (qbox && cmd.slot <= SLOT_CORNER_END) begin
			kind_box = 1'b0;
			ox = TW'(cidx[2]);
			oy = TW'(cidx[1]);
			oz = TW'(cidx[0]);
		end else begin
			if (fidx == 3'd0 || fidx == 3'd3) ox = fstep;
			if (fidx == 3'd1 || fidx == 3'd4) oy = fstep;
			if (fidx == 3'd2 || fidx == 3'd5) oz = fstep;
		end
		tx = TW'(item_q.coord_x) + ox;
		ty = TW'(item_q.coord_y) + oy;
		tz = TW'(item_q.coord_z) + oz;
		if (kind_box)
			t_inr = (tx < TW'(n)) && (ty < TW'(n)) && (tz < TW'(n));
		else
			t_inr = (tx <= TW'(n)) && (ty <= TW'(n)) && (tz <= TW'(n));
	end

	// occupancy read address
	logic [BOX_AW-1:0] walk_baddr, occ_raddr;
	logic              occ_re;
	always_comb begin
		walk_baddr = box_addr(TW'(wx_q), TW'(wy_q), TW'(wz_q));
		unique case (cmd.op)
			DP_BOX_WALK:  occ_raddr = walk_baddr;
			DP_NODE_WALK: occ_raddr = box_addr(nbx, nby, nbz);
			default:      occ_raddr = box_addr(tx, ty, tz);
		endcase
		occ_re = (cmd.op == DP_BOX_WALK) || (cmd.op == DP_NODE_WALK) || (cmd.op == DP_READ);
	end

	// load write
	logic load_inr;
	assign load_inr = (item_q.coord_x < n) && (item_q.coord_y < n) && (item_q.coord_z < n);

	// occupancy memory
	always_ff @(posedge clk) begin
		if (cmd.op == DP_CLEAR)
			occ_mem[walk_baddr] <= 1'b0;
		else if (cmd.op == DP_LOAD && load_inr)
			occ_mem[box_addr(TW'(item_q.coord_x), TW'(item_q.coord_y),
				TW'(item_q.coord_z))] <= item_q.occupied;
		if (occ_re)
			occ_rd_q <= occ_mem[occ_raddr];
	end

	// box index memory
	always_ff @(posedge clk) begin
		if (bw_v_s1 && occ_rd_q)
			box_idx_mem[bw_addr_s1] <= box_cnt_q[BOX_AW-1:0];
		if (cmd.op == DP_READ)
			box_rd_q <= box_idx_mem[box_addr(tx, ty, tz)];
	end

	// node memories
	logic              touch;
	logic [NODE_AW-1:0] walk_naddr;
	always_comb begin
		touch      = touch_q | (nw_v_s1 & inr_s1 & occ_rd_q);
		walk_naddr = node_addr(TW'(wx_q), TW'(wy_q), TW'(wz_q));
	end

	always_ff @(posedge clk) begin
		if (node_step_end) begin
			present_mem[walk_naddr] <= touch;
			if (touch)
				node_idx_mem[walk_naddr] <= node_cnt_q;
		end
		if (cmd.op == DP_READ) begin
			present_rd_q <= present_mem[node_addr(tx, ty, tz)];
			node_rd_q    <= node_idx_mem[node_addr(tx, ty, tz)];
		end
	end

	// control registers, walk counters and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= '0;
			grid_size_q <= CW'(MAX_RES);
			built_q     <= 1'b0;
			box_cnt_q   <= '0;
			node_cnt_q  <= '0;
			wx_q        <= '0;
			wy_q        <= '0;
			wz_q        <= '0;
			wsub_q      <= '0;
			touch_q     <= 1'b0;
			bw_v_s1     <= 1'b0;
			nw_v_s1     <= 1'b0;
			inr_s1      <= 1'b0;
			kind_box_s1 <= 1'b0;
			bw_addr_s1  <= '0;
		end else begin
			if (cmd.capture) item_q <= in_item;
			// built flag
			if (cfg_valid) begin
				grid_size_q <= cfg_data;
				built_q     <= 1'b0;
			end else if (cmd.op == DP_LOAD && load_inr) begin
				built_q <= 1'b0;
			end else if (cmd.set_built) begin
				built_q <= 1'b1;
			end
			// box numbering pipeline
			bw_v_s1    <= (cmd.op == DP_BOX_WALK);
			bw_addr_s1 <= walk_baddr;
			if (cmd.count_clr) begin
				box_cnt_q  <= '0;
				node_cnt_q <= '0;
			end else begin
				if (bw_v_s1 && occ_rd_q) box_cnt_q <= box_cnt_q + VW'(1);
				if (node_step_end && touch) node_cnt_q <= node_cnt_q + VW'(1);
			end
			// corner probes of the node walk
			nw_v_s1 <= (cmd.op == DP_NODE_WALK) && (wsub_q < 4'd8);
			if (cmd.op == DP_NODE_WALK) begin
				inr_s1  <= nb_inr;
				touch_q <= node_step_end ? 1'b0 : touch;
				wsub_q  <= node_step_end ? 4'd0 : wsub_q + 4'd1;
			end else if (cmd.op == DP_READ) begin
				inr_s1      <= t_inr;
				kind_box_s1 <= kind_box;
			end
			// scan order walk, z innermost
			if (walk_adv) begin
				if (wz_q != lim) begin
					wz_q <= wz_q + CW'(1);
				end else begin
					wz_q <= '0;
					if (wy_q != lim) begin
						wy_q <= wy_q + CW'(1);
					end else begin
						wy_q <= '0;
						wx_q <= walk_last ? '0 : wx_q + CW'(1);
					end
				end
			end
		end
	end

	// result of a memory read
	logic          mem_found;
	logic [VW-1:0] mem_value;
	always_comb begin
		mem_found = inr_s1 & (kind_box_s1 ? occ_rd_q : present_rd_q)
			& ((cmd.slot == '0) ? built_q : 1'b1);
		if (!mem_found) mem_value = '0;
		else if (kind_box_s1) mem_value = VW'(box_rd_q);
		else mem_value = VW'(node_rd_q);
	end

	// output register
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (cmd.op == DP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
			out_q.slot  <= cmd.slot;
			unique case (cmd.src)
				SRC_BOX_CNT: begin
					out_q.index_value <= box_cnt_q;
					out_q.found       <= 1'b1;
					out_q.last        <= cmd.last;
				end
				SRC_NODE_CNT: begin
					out_q.index_value <= node_cnt_q;
					out_q.found       <= 1'b1;
					out_q.last        <= cmd.last;
				end
				default: begin
					out_q.index_value <= mem_value;
					out_q.found       <= mem_found;
					out_q.last        <= cmd.last | ((cmd.slot == '0) & ~mem_found);
				end
			endcase
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		status.walk_done = walk_last && ((cmd.op != DP_NODE_WALK) || (wsub_q == 4'd8));
		status.found     = mem_found;
		status.out_free  = out_free;
		status.item_cmd  = item_q.cmd;
	end

endmodule

/* design/vgib_ctrl.sv */
// controller of the voxel grid index builder: sequences clear, load, build and queries
// depends on vgib_pkg; drives the datapath by command, reads its status
module vgib_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  vgib_pkg::dp_status_t status,
	output vgib_pkg::dp_cmd_t    cmd
);
	import vgib_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_BOX_WALK,
		ST_BOX_DRAIN,
		ST_NODE_WALK,
		ST_EMIT_BOX,
		ST_EMIT_NODE,
		ST_Q_READ,
		ST_Q_EMIT
	} state_t;

	state_t        state_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] final_slot;
	logic          accept;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign final_slot = (status.item_cmd == CMD_QBOX) ? SLOT_BOX_FINAL : SLOT_NODE_FINAL;

	// commands per state
	always_comb begin
		cmd = '{op: DP_NOP, capture: accept, count_clr: 1'b0, set_built: 1'b0,
			src: SRC_MEM, slot: slot_q, last: 1'b0};
		unique case (state_q)
			ST_CLEAR:     cmd.op = DP_CLEAR;
			ST_DECODE: begin
				if (status.item_cmd == CMD_LOAD) cmd.op = DP_LOAD;
				cmd.count_clr = (status.item_cmd == CMD_BUILD);
			end
			ST_BOX_WALK:  cmd.op = DP_BOX_WALK;
			ST_NODE_WALK: begin
				cmd.op        = DP_NODE_WALK;
				cmd.set_built = status.walk_done;
			end
			ST_EMIT_BOX: begin
				cmd.op   = DP_EMIT;
				cmd.src  = SRC_BOX_CNT;
				cmd.slot = '0;
			end
			ST_EMIT_NODE: begin
				cmd.op   = DP_EMIT;
				cmd.src  = SRC_NODE_CNT;
				cmd.slot = SW'(1);
				cmd.last = 1'b1;
			end
			ST_Q_READ:    cmd.op = DP_READ;
			ST_Q_EMIT: begin
				cmd.op   = DP_EMIT;
				cmd.last = (slot_q == final_slot);
			end
			default:      cmd.op = DP_NOP;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR:     if (status.walk_done) state_q <= ST_IDLE;
				ST_IDLE:      if (accept) state_q <= ST_DECODE;
				ST_DECODE: begin
					slot_q <= '0;
					unique case (status.item_cmd)
						CMD_LOAD:  state_q <= ST_IDLE;
						CMD_BUILD: state_q <= ST_BOX_WALK;
						default:   state_q <= ST_Q_READ;
					endcase
				end
				ST_BOX_WALK:  if (status.walk_done) state_q <= ST_BOX_DRAIN;
				ST_BOX_DRAIN: state_q <= ST_NODE_WALK;
				ST_NODE_WALK: if (status.walk_done) state_q <= ST_EMIT_BOX;
				ST_EMIT_BOX:  if (status.out_free) state_q <= ST_EMIT_NODE;
				ST_EMIT_NODE: if (status.out_free) state_q <= ST_IDLE;
				ST_Q_READ:    state_q <= ST_Q_EMIT;
				ST_Q_EMIT: begin
					if (status.out_free) begin
						if (slot_q == final_slot || (slot_q == '0 && !status.found)) begin
							state_q <= ST_IDLE;
						end else begin
							slot_q  <= slot_q + SW'(1);
							state_q <= ST_Q_READ;
						end
					end
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/voxel_grid_index_builder_top.sv */
// top level of the voxel grid index builder
// depends on vgib_pkg, vgib_ctrl and vgib_datapath
//
// usage:
//  request channel in_valid / in_stall / in_item: load voxel, build, query box, query node.
//  result channel out_valid / out_stall / out_item: one result per slot, last on the final.
//  config channel cfg_valid / cfg_ready / cfg_data: grid_size, always ready; write only
//  while idle. a write or an in-grid load invalidates the indices.
//  after reset the occupancy map is cleared with in_stall high.
//  query: each result comes from one shared read of the four memories.
//  build: one occupancy read per box, then eight occupancy reads per lattice
//  node on the single read port, then two results.
//  results sit in an output register; when out_stall is high the sequencer
//  waits with the next result and in_stall stays high until the request is done.
module voxel_grid_index_builder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vgib_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output vgib_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [5:0]          cfg_data
);
	import vgib_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	vgib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// memories and result register
	vgib_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (in_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

`ifndef NO_ASSERTIONS
	// a not-found slot 0 closes the answer
	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.slot == '0 && !out_item.found |-> out_item.last)
		else $error("not-found slot 0 without last");

	// absent entries carry a zero index
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.index_value == '0)
		else $error("absent entry with non-zero index");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");
`endif

endmodule
